// ----- rtl/core/route_table_engine_top_defines.svh -----
// assertion macros for the route table engine
// expects clk and rst_n in the scope that uses them; no other dependencies
`ifndef ROUTE_TABLE_ENGINE_TOP_DEFINES_SVH
`define ROUTE_TABLE_ENGINE_TOP_DEFINES_SVH

// condition that must hold at every edge out of reset
`define RTE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define RTE_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/core/rte_pkg.sv -----
// shared types and constants of the route table engine
// no dependencies
package rte_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = 7;

    localparam logic [2:0] MODE_LOOKUP     = 3'd0;
    localparam logic [2:0] MODE_ADD        = 3'd1;
    localparam logic [2:0] MODE_UPDATE     = 3'd2;
    localparam logic [2:0] MODE_DELETE     = 3'd3;
    localparam logic [2:0] MODE_DEL_IFACE  = 3'd4;
    localparam logic [2:0] MODE_PURGE      = 3'd5;
    localparam logic [2:0] MODE_LIST_VALID = 3'd6;
    localparam logic [2:0] MODE_LIST_NH    = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] gateway;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] life;
        logic [3:0]  iface;
        logic [31:0] bcast;
        logic        valid;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [2:0] mode;
        entry_t     ent;
        logic       fri;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        entry_t           ent;
        logic [CNT_W-1:0] count;
        logic             last;
    } result_t;

endpackage

// ----- rtl/core/rte_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/rte_out_reg.sv -----
// output register stage of the route table engine
// depends on rte_pkg
module rte_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  rte_pkg::result_t res,
    output logic             res_ready,
    output logic             result_valid,
    input  logic             result_stall,
    output rte_pkg::result_t result_q
);

    logic             ovalid_reg;
    logic             ovalid_next;
    rte_pkg::result_t data_reg;
    rte_pkg::result_t data_next;

    assign res_ready    = !ovalid_reg || !result_stall;
    assign result_valid = ovalid_reg;
    assign result_q     = data_reg;

    always_comb
    begin
        ovalid_next = ovalid_reg;
        data_next   = data_reg;
        if (res_valid && res_ready)
        begin
            ovalid_next = 1'b1;
            data_next   = res;
        end
        else if (!result_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- rtl/core/rte_engine.sv -----
// table sequencer: scans the entry ram, keeps slot use and result marks
// depends on rte_pkg and rte_ram
module rte_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rte_pkg::item_t   item_in,
    input  logic [31:0]      holddown,
    output logic             res_valid,
    output rte_pkg::result_t res,
    input  logic             res_ready
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SINGLE   = 3'd4;
    localparam logic [2:0] S_EMIT_CHK = 3'd5;
    localparam logic [2:0] S_EMIT_OUT = 3'd6;

    localparam logic [2:0] PH_FIND  = 3'd0;
    localparam logic [2:0] PH_IFACE = 3'd1;
    localparam logic [2:0] PH_LIST  = 3'd2;
    localparam logic [2:0] PH_MIN   = 3'd3;
    localparam logic [2:0] PH_KILL  = 3'd4;

    localparam int D  = rte_pkg::TABLE_DEPTH;
    localparam int SW = rte_pkg::SLOT_W;
    localparam int CW = rte_pkg::CNT_W;

    logic [2:0]      state_reg, state_next;
    logic [2:0]      phase_reg, phase_next;
    rte_pkg::item_t  item_reg, item_next;
    logic [SW-1:0]   scan_addr_reg, scan_addr_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [SW-1:0]   rsp_slot_reg, rsp_slot_next;
    logic [D-1:0]    used_reg, used_next;
    logic [D-1:0]    mark_reg, mark_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            hit_reg, hit_next;
    logic [SW-1:0]   hit_slot_reg, hit_slot_next;
    rte_pkg::entry_t hit_ent_reg, hit_ent_next;
    logic            free_found_reg, free_found_next;
    logic [SW-1:0]   free_slot_reg, free_slot_next;
    logic            any_reg, any_next;
    logic            started_reg, started_next;
    logic [31:0]     prev_reg, prev_next;
    logic            cand_reg, cand_next;
    logic [SW-1:0]   cand_slot_reg, cand_slot_next;
    rte_pkg::entry_t cand_ent_reg, cand_ent_next;
    logic [1:0]      hold_status_reg, hold_status_next;
    rte_pkg::entry_t hold_ent_reg, hold_ent_next;
    logic [SW-1:0]   ptr_reg, ptr_next;

    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    rte_pkg::entry_t ram_wdata;
    logic            ram_re;
    logic [SW-1:0]   ram_raddr;
    logic [rte_pkg::ENTRY_W-1:0] ram_rdata;
    rte_pkg::entry_t rent;
    logic            rused;
    logic [D-1:0]    mark_rest;
    logic            emit_last;

    rte_ram #(
        .WIDTH (rte_pkg::ENTRY_W),
        .DEPTH (D)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rent       = rte_pkg::entry_t'(ram_rdata);
    assign rused      = used_reg[rsp_slot_reg];
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        mark_rest          = mark_reg;
        mark_rest[ptr_reg] = 1'b0;
        emit_last          = (mark_rest == '0);
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        item_next        = item_reg;
        scan_addr_next   = scan_addr_reg;
        rsp_valid_next   = 1'b0;
        rsp_slot_next    = rsp_slot_reg;
        used_next        = used_reg;
        mark_next        = mark_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        hit_slot_next    = hit_slot_reg;
        hit_ent_next     = hit_ent_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        any_next         = any_reg;
        started_next     = started_reg;
        prev_next        = prev_reg;
        cand_next        = cand_reg;
        cand_slot_next   = cand_slot_reg;
        cand_ent_next    = cand_ent_reg;
        hold_status_next = hold_status_reg;
        hold_ent_next    = hold_ent_reg;
        ptr_next         = ptr_reg;

        ram_we    = 1'b0;
        ram_waddr = hit_slot_reg;
        ram_wdata = item_reg.ent;
        ram_re    = 1'b0;
        ram_raddr = scan_addr_reg;

        res_valid  = 1'b0;
        res.status = hold_status_reg;
        res.ent    = hold_ent_reg;
        res.count  = count_reg;
        res.last   = 1'b1;

        // entry read during a scan comes back in the next cycle
        if (rsp_valid_reg)
        begin
            unique case (phase_reg)
                PH_FIND:
                begin
                    if (rused && rent.dest == item_reg.ent.dest)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = rsp_slot_reg;
                        hit_ent_next  = rent;
                    end
                    if (!rused && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = rsp_slot_reg;
                    end
                end
                PH_IFACE:
                begin
                    if (rused && rent.iface == item_reg.ent.iface)
                    begin
                        used_next[rsp_slot_reg] = 1'b0;
                        any_next                = 1'b1;
                        count_next              = count_reg - 1'b1;
                    end
                end
                PH_LIST:
                begin
                    if (item_reg.mode == rte_pkg::MODE_LIST_VALID)
                    begin
                        if (rused && rent.dest != rte_pkg::LOOPBACK_ADDR && rent.valid)
                        begin
                            mark_next[rsp_slot_reg] = 1'b1;
                        end
                    end
                    else if (rused && rent.gateway == item_reg.ent.gateway)
                    begin
                        mark_next[rsp_slot_reg] = 1'b1;
                    end
                end
                PH_MIN:
                begin
                    if (rused && (!started_reg || rent.dest > prev_reg) &&
                        (!cand_reg || rent.dest < cand_ent_reg.dest))
                    begin
                        cand_next      = 1'b1;
                        cand_slot_next = rsp_slot_reg;
                        cand_ent_next  = rent;
                    end
                end
                PH_KILL:
                begin
                    if (rused && rent.gateway == cand_ent_reg.dest &&
                        rent.hops != cand_ent_reg.hops)
                    begin
                        used_next[rsp_slot_reg] = 1'b0;
                        mark_next[rsp_slot_reg] = 1'b1;
                        count_next              = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next       = item_in;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    any_next        = 1'b0;
                    started_next    = 1'b0;
                    cand_next       = 1'b0;
                    scan_addr_next  = '0;
                    state_next      = S_SCAN;
                    case (item_in.mode)
                        rte_pkg::MODE_DEL_IFACE: phase_next = PH_IFACE;
                        rte_pkg::MODE_PURGE:     phase_next = PH_MIN;
                        rte_pkg::MODE_LIST_VALID,
                        rte_pkg::MODE_LIST_NH:   phase_next = PH_LIST;
                        default:                 phase_next = PH_FIND;
                    endcase
                end
            end
            S_SCAN:
            begin
                ram_re         = 1'b1;
                ram_raddr      = scan_addr_reg;
                rsp_valid_next = 1'b1;
                rsp_slot_next  = scan_addr_reg;
                if (scan_addr_reg == SW'(D - 1))
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                hold_status_next = rte_pkg::ST_MISS;
                hold_ent_next    = '0;
                state_next       = S_SINGLE;
                unique case (phase_reg)
                    PH_FIND:
                    begin
                        case (item_reg.mode)
                            rte_pkg::MODE_LOOKUP:
                            begin
                                if (hit_reg && !(item_reg.fri &&
                                    item_reg.ent.dest == hit_ent_reg.bcast))
                                begin
                                    hold_status_next = rte_pkg::ST_OK;
                                    hold_ent_next    = hit_ent_reg;
                                end
                            end
                            rte_pkg::MODE_ADD:
                            begin
                                if (hit_reg)
                                begin
                                    hold_status_next = rte_pkg::ST_MISS;
                                end
                                else if (!free_found_reg)
                                begin
                                    hold_status_next = rte_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ram_we                    = 1'b1;
                                    ram_waddr                 = free_slot_reg;
                                    used_next[free_slot_reg]  = 1'b1;
                                    count_next                = count_reg + 1'b1;
                                    hold_status_next          = rte_pkg::ST_OK;
                                    hold_ent_next             = item_reg.ent;
                                end
                            end
                            rte_pkg::MODE_UPDATE:
                            begin
                                if (hit_reg)
                                begin
                                    ram_we           = 1'b1;
                                    ram_waddr        = hit_slot_reg;
                                    hold_status_next = rte_pkg::ST_OK;
                                    hold_ent_next    = item_reg.ent;
                                end
                            end
                            default:
                            begin
                                if (hit_reg)
                                begin
                                    used_next[hit_slot_reg] = 1'b0;
                                    count_next              = count_reg - 1'b1;
                                    hold_status_next        = rte_pkg::ST_OK;
                                    hold_ent_next           = hit_ent_reg;
                                end
                            end
                        endcase
                    end
                    PH_IFACE:
                    begin
                        hold_status_next = any_reg ? rte_pkg::ST_OK : rte_pkg::ST_MISS;
                    end
                    PH_MIN:
                    begin
                        if (cand_reg)
                        begin
                            started_next   = 1'b1;
                            prev_next      = cand_ent_reg.dest;
                            scan_addr_next = '0;
                            state_next     = S_SCAN;
                            if (cand_ent_reg.life > holddown && cand_ent_reg.hops != 8'd0)
                            begin
                                phase_next = PH_KILL;
                            end
                            else
                            begin
                                cand_next = 1'b0;
                            end
                        end
                        else if (mark_reg != '0)
                        begin
                            ptr_next   = '0;
                            state_next = S_EMIT_CHK;
                        end
                    end
                    PH_KILL:
                    begin
                        used_next[cand_slot_reg] = 1'b0;
                        mark_next[cand_slot_reg] = 1'b1;
                        count_next               = count_reg - 1'b1;
                        cand_next                = 1'b0;
                        phase_next               = PH_MIN;
                        scan_addr_next           = '0;
                        state_next               = S_SCAN;
                    end
                    default:
                    begin
                        if (mark_reg != '0)
                        begin
                            ptr_next   = '0;
                            state_next = S_EMIT_CHK;
                        end
                    end
                endcase
            end
            S_SINGLE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_CHK:
            begin
                if (mark_reg[ptr_reg])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ptr_reg;
                    state_next = S_EMIT_OUT;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_EMIT_OUT:
            begin
                res_valid  = 1'b1;
                res.status = rte_pkg::ST_OK;
                res.ent    = rent;
                res.last   = emit_last;
                if (res_ready)
                begin
                    mark_next[ptr_reg] = 1'b0;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = S_EMIT_CHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FIND;
            scan_addr_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            used_reg       <= '0;
            mark_reg       <= '0;
            count_reg      <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            started_reg    <= 1'b0;
            cand_reg       <= 1'b0;
            ptr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            scan_addr_reg  <= scan_addr_next;
            rsp_valid_reg  <= rsp_valid_next;
            used_reg       <= used_next;
            mark_reg       <= mark_next;
            count_reg      <= count_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            any_reg        <= any_next;
            started_reg    <= started_next;
            cand_reg       <= cand_next;
            ptr_reg        <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        rsp_slot_reg    <= rsp_slot_next;
        hit_slot_reg    <= hit_slot_next;
        hit_ent_reg     <= hit_ent_next;
        free_slot_reg   <= free_slot_next;
        prev_reg        <= prev_next;
        cand_slot_reg   <= cand_slot_next;
        cand_ent_reg    <= cand_ent_next;
        hold_status_reg <= hold_status_next;
        hold_ent_reg    <= hold_ent_next;
    end

endmodule

// ----- rtl/core/route_table_engine_top.sv -----
// top level of the route table engine: ports, holddown register, assertions
// depends on rte_pkg, rte_engine, rte_out_reg and route_table_engine_top_defines.svh
`include "route_table_engine_top_defines.svh"

// Route table with one entry per destination address and TABLE_DEPTH (64) slots.
// All entry fields live in one synchronous ram read one slot per cycle; only the
// slot-in-use bits, the result marks and the entry count sit in flip-flops, so
// reset empties the table at once with no clearing pass. Every item starts with
// a full walk of the ram (a read of each slot, the return of the last read, then
// a decide step): lookup, add, update, delete and delete-interface then hand
// their single result to the output register, and the next item can be taken
// once that result is accepted there. The list modes mark matching slots during
// that walk and then step through the marks up to the last one, passing over
// each unmarked slot and sending one result per marked slot. Purge repeats the
// walk once per entry it visits in ascending destination order (finding the
// next smallest address) and once more for each expired entry (removing routes
// through it), then steps through the removed entries as the list modes do. The
// ram port is the limit in every mode. A new item is taken while the last result
// of the previous one still waits in the output register. The holddown register
// is written over its own channel, always ready, and must only be written while
// no item is in progress.
module route_table_engine_top (
    input  logic        clk,
    input  logic        rst_n,

    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  mode,
    input  logic [31:0] dest_addr,
    input  logic [31:0] next_hop,
    input  logic [7:0]  hop_count,
    input  logic [31:0] seq_number,
    input  logic [31:0] life_ticks,
    input  logic [3:0]  iface_id,
    input  logic [31:0] iface_bcast,
    input  logic        route_valid,
    input  logic        for_route_input,

    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] out_dest,
    output logic [31:0] out_next_hop,
    output logic [7:0]  out_hops,
    output logic [31:0] out_seq,
    output logic [31:0] out_life,
    output logic [3:0]  out_iface,
    output logic        out_valid,
    output logic [6:0]  entry_count,
    output logic        last,

    // holddown register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0]      holddown_reg;
    logic [31:0]      holddown_next;
    rte_pkg::item_t   item_in;
    logic             res_valid;
    logic             res_ready;
    rte_pkg::result_t res;
    rte_pkg::result_t result_q;

    // register transfer completes in any cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        holddown_next = holddown_reg;
        if (cfg_valid && cfg_ready)
        begin
            holddown_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holddown_reg <= '0;
        end
        else
        begin
            holddown_reg <= holddown_next;
        end
    end

    // pack the item fields; the key, gateway and interface also act as match keys
    assign item_in.mode          = mode;
    assign item_in.ent.dest      = dest_addr;
    assign item_in.ent.gateway   = next_hop;
    assign item_in.ent.hops      = hop_count;
    assign item_in.ent.seq       = seq_number;
    assign item_in.ent.life      = life_ticks;
    assign item_in.ent.iface     = iface_id;
    assign item_in.ent.bcast     = iface_bcast;
    assign item_in.ent.valid     = route_valid;
    assign item_in.fri           = for_route_input;

    rte_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .holddown   (holddown_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // output register decouples the sequencer from the result stall
    rte_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_q     (result_q)
    );

    assign status       = result_q.status;
    assign out_dest     = result_q.ent.dest;
    assign out_next_hop = result_q.ent.gateway;
    assign out_hops     = result_q.ent.hops;
    assign out_seq      = result_q.ent.seq;
    assign out_life     = result_q.ent.life;
    assign out_iface    = result_q.ent.iface;
    assign out_valid    = result_q.ent.valid;
    assign entry_count  = result_q.count;
    assign last         = result_q.last;

    // an accepted item always keeps the sequencer busy for at least one scan
    `RTE_ASSERT_NEXT(a_item_busy, item_valid && !item_stall, item_stall, "item accepted but engine not busy")
    // the entry count can never exceed the number of slots
    `RTE_ASSERT_ALWAYS(a_count_range, !result_valid || entry_count <= 7'(rte_pkg::TABLE_DEPTH), "entry count above table depth")
    // a miss or full status carries no entry
    `RTE_ASSERT_ALWAYS(a_miss_zero, !result_valid || status == rte_pkg::ST_OK || (out_dest == 32'd0 && out_next_hop == 32'd0 && out_hops == 8'd0 && out_valid == 1'b0), "failed result carries entry data")
    // a full table is reported as the only result of an add
    `RTE_ASSERT_ALWAYS(a_full_last, !result_valid || status != rte_pkg::ST_FULL || last, "table full result not final")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench of route_table_engine_top: directed table, table fill and purges, then random route items
// depends on rte_pkg and the route_table_engine_top rtl
module tb_top;

    // one returned result, as seen on the result port
    typedef struct {
        logic [1:0]  status;
        logic [31:0] dest;
        logic [31:0] gw;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] life;
        logic [3:0]  iface;
        logic        valid;
        logic [6:0]  count;
        logic        last;
    } route_res_t;

    // one row of the directed table; chk set when the result is typed in
    typedef struct {
        logic [2:0]  mode;
        logic [31:0] dest;
        logic [31:0] gw;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] life;
        logic [3:0]  iface;
        logic [31:0] bcast;
        logic        valid;
        logic        fri;
        logic        chk;
        logic [1:0]  x_status;
        logic [6:0]  x_count;
    } route_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [2:0]  mode = rte_pkg::MODE_LOOKUP;
    logic [31:0] dest_addr = '0;
    logic [31:0] next_hop = '0;
    logic [7:0]  hop_count = '0;
    logic [31:0] seq_number = '0;
    logic [31:0] life_ticks = '0;
    logic [3:0]  iface_id = '0;
    logic [31:0] iface_bcast = '0;
    logic        route_valid = 1'b0;
    logic        for_route_input = 1'b0;

    logic        result_valid;
    logic        result_stall = 1'b1;
    logic [1:0]  status;
    logic [31:0] out_dest;
    logic [31:0] out_next_hop;
    logic [7:0]  out_hops;
    logic [31:0] out_seq;
    logic [31:0] out_life;
    logic [3:0]  out_iface;
    logic        out_valid;
    logic [6:0]  entry_count;
    logic        last;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // shadow of the route table kept by the predictor
    logic        rt_used  [rte_pkg::TABLE_DEPTH];
    logic [31:0] rt_dest  [rte_pkg::TABLE_DEPTH];
    logic [31:0] rt_gw    [rte_pkg::TABLE_DEPTH];
    logic [7:0]  rt_hops  [rte_pkg::TABLE_DEPTH];
    logic [31:0] rt_seq   [rte_pkg::TABLE_DEPTH];
    logic [31:0] rt_life  [rte_pkg::TABLE_DEPTH];
    logic [3:0]  rt_iface [rte_pkg::TABLE_DEPTH];
    logic [31:0] rt_bcast [rte_pkg::TABLE_DEPTH];
    logic        rt_valid [rte_pkg::TABLE_DEPTH];
    logic [31:0] holddown = '0;

    route_res_t pending_routes[$];
    int  mismatches = 0;
    bit  rx_quiet = 1'b0;     // no random stalls on the receiver
    bit  tx_quiet = 1'b0;     // no random gaps on the sender
    bit  hold_rx = 1'b0;      // long receiver hold-off request
    bit  fails_seen = 1'b0;

    route_table_engine_top dut (.*);

    always #1 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic int slot_of(logic [31:0] key);
        for (int s = 0; s < rte_pkg::TABLE_DEPTH; s++)
            if (rt_used[s] && rt_dest[s] == key)
                return s;
        return -1;
    endfunction

    function automatic route_res_t entry_res(int s, logic [1:0] st);
        route_res_t r;
        r = '{default: '0};
        r.status = st;
        if (s >= 0)
        begin
            r.dest  = rt_dest[s];
            r.gw    = rt_gw[s];
            r.hops  = rt_hops[s];
            r.seq   = rt_seq[s];
            r.life  = rt_life[s];
            r.iface = rt_iface[s];
            r.valid = rt_valid[s];
        end
        return r;
    endfunction

    function automatic void store_route(int s, route_row_t it);
        rt_dest[s]  = it.dest;
        rt_gw[s]    = it.gw;
        rt_hops[s]  = it.hops;
        rt_seq[s]   = it.seq;
        rt_life[s]  = it.life;
        rt_iface[s] = it.iface;
        rt_bcast[s] = it.bcast;
        rt_valid[s] = it.valid;
    endfunction

    // applies one item to the shadow table and queues its results
    function automatic void predict_route_op(route_row_t it);
        route_res_t outs[$];
        int  s;
        int  cur;
        int  cnt;
        bit  any;
        bit  started;
        bit  gone[rte_pkg::TABLE_DEPTH];
        logic [31:0] prev;
        for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
            gone[k] = 1'b0;
        s = slot_of(it.dest);
        case (it.mode)
            rte_pkg::MODE_LOOKUP:
                if (s < 0 || (it.fri && it.dest == rt_bcast[s]))
                    outs.push_back(entry_res(-1, rte_pkg::ST_MISS));
                else
                    outs.push_back(entry_res(s, rte_pkg::ST_OK));
            rte_pkg::MODE_ADD:
            begin
                if (s >= 0)
                    outs.push_back(entry_res(-1, rte_pkg::ST_MISS));
                else
                begin
                    for (s = 0; s < rte_pkg::TABLE_DEPTH && rt_used[s]; s++) ;
                    if (s >= rte_pkg::TABLE_DEPTH)
                        outs.push_back(entry_res(-1, rte_pkg::ST_FULL));
                    else
                    begin
                        store_route(s, it);
                        rt_used[s] = 1'b1;
                        outs.push_back(entry_res(s, rte_pkg::ST_OK));
                    end
                end
            end
            rte_pkg::MODE_UPDATE:
                if (s < 0)
                    outs.push_back(entry_res(-1, rte_pkg::ST_MISS));
                else
                begin
                    store_route(s, it);
                    outs.push_back(entry_res(s, rte_pkg::ST_OK));
                end
            rte_pkg::MODE_DELETE:
                if (s < 0)
                    outs.push_back(entry_res(-1, rte_pkg::ST_MISS));
                else
                begin
                    outs.push_back(entry_res(s, rte_pkg::ST_OK));
                    rt_used[s] = 1'b0;
                end
            rte_pkg::MODE_DEL_IFACE:
            begin
                any = 1'b0;
                for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
                    if (rt_used[k] && rt_iface[k] == it.iface)
                    begin
                        rt_used[k] = 1'b0;
                        any = 1'b1;
                    end
                outs.push_back(entry_res(-1, any ? rte_pkg::ST_OK : rte_pkg::ST_MISS));
            end
            rte_pkg::MODE_PURGE:
            begin
                // visit in ascending destination order, removing expired routes
                started = 1'b0;
                prev = '0;
                forever
                begin
                    cur = -1;
                    for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
                    begin
                        if (!rt_used[k] || (started && rt_dest[k] <= prev))
                            continue;
                        if (cur < 0 || rt_dest[k] < rt_dest[cur])
                            cur = k;
                    end
                    if (cur < 0)
                        break;
                    started = 1'b1;
                    prev = rt_dest[cur];
                    if (rt_life[cur] > holddown && rt_hops[cur] > 0)
                    begin
                        for (int j = 0; j < rte_pkg::TABLE_DEPTH; j++)
                            if (rt_used[j] && rt_gw[j] == rt_dest[cur]
                                && rt_hops[j] != rt_hops[cur])
                            begin
                                rt_used[j] = 1'b0;
                                gone[j] = 1'b1;
                            end
                        rt_used[cur] = 1'b0;
                        gone[cur] = 1'b1;
                    end
                end
                for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
                    if (gone[k])
                        outs.push_back(entry_res(k, rte_pkg::ST_OK));
            end
            rte_pkg::MODE_LIST_VALID:
                for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
                    if (rt_used[k] && rt_dest[k] != rte_pkg::LOOPBACK_ADDR && rt_valid[k])
                        outs.push_back(entry_res(k, rte_pkg::ST_OK));
            default:
                for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
                    if (rt_used[k] && rt_gw[k] == it.gw)
                        outs.push_back(entry_res(k, rte_pkg::ST_OK));
        endcase
        if (outs.size() == 0)
            outs.push_back(entry_res(-1, rte_pkg::ST_MISS));
        cnt = 0;
        for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
            cnt += rt_used[k];
        foreach (outs[k])
        begin
            outs[k].count = cnt[6:0];
            outs[k].last = (k == outs.size() - 1);
            pending_routes.push_back(outs[k]);
        end
    endfunction

    // ---------------- sender ----------------

    task automatic send_route_op(route_row_t it);
        @(negedge clk);
        if (!tx_quiet)
            while ($urandom_range(99) < 32)
                @(negedge clk);
        predict_route_op(it);
        item_valid      <= 1'b1;
        mode            <= it.mode;
        dest_addr       <= it.dest;
        next_hop        <= it.gw;
        hop_count       <= it.hops;
        seq_number      <= it.seq;
        life_ticks      <= it.life;
        iface_id        <= it.iface;
        iface_bcast     <= it.bcast;
        route_valid     <= it.valid;
        for_route_input <= it.fri;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // waits for every expected result, then for the item walk to settle
    task automatic drain_routes();
        while (pending_routes.size() != 0)
            @(negedge clk);
        repeat (2 * rte_pkg::TABLE_DEPTH * rte_pkg::TABLE_DEPTH + 400)
            @(negedge clk);
    endtask

    task automatic write_holddown(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        holddown = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random route item; keys drawn from a small pool so hits are common
    function automatic route_row_t rand_route(int pool);
        route_row_t it;
        it = '{default: '0};
        it.mode  = $urandom_range(99) < 40 ? rte_pkg::MODE_ADD : 3'($urandom_range(7));
        it.dest  = $urandom_range(7) == 0 ? $urandom() : 32'(32'h0a00_0000 + $urandom_range(pool));
        it.gw    = $urandom_range(3) == 0 ? $urandom()
                 : 32'(32'h0a00_0000 + $urandom_range(pool));
        it.hops  = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(3));
        it.seq   = $urandom();
        it.life  = $urandom_range(1) ? $urandom() : 32'($urandom_range(200));
        it.iface = 4'($urandom());
        it.bcast = $urandom_range(3) == 0 ? it.dest : $urandom();
        it.valid = 1'($urandom_range(1));
        it.fri   = 1'($urandom_range(1));
        if ($urandom_range(19) == 0)
            it.dest = rte_pkg::LOOPBACK_ADDR;
        return it;
    endfunction

    // ---------------- receiver and checker ----------------

    always @(negedge clk)
    begin
        if (hold_rx)
            result_stall <= 1'b1;
        else if (rx_quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 32);
    end

    always @(posedge clk)
    begin
        route_res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: dest %h status %0d", out_dest, status);
            end
            else
            begin
                want = pending_routes.pop_front();
                if (status !== want.status || out_dest !== want.dest
                    || out_next_hop !== want.gw || out_hops !== want.hops
                    || out_seq !== want.seq || out_life !== want.life
                    || out_iface !== want.iface || out_valid !== want.valid
                    || entry_count !== want.count || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp st %0d d %h g %h h %0d s %h l %h",
                                  " i %0d v %0d c %0d last %0d / got st %0d d %h g %h",
                                  " h %0d s %h l %h i %0d v %0d c %0d last %0d"},
                            want.status, want.dest, want.gw, want.hops, want.seq, want.life,
                            want.iface, want.valid, want.count, want.last,
                            status, out_dest, out_next_hop, out_hops, out_seq, out_life,
                            out_iface, out_valid, entry_count, last);
                end
            end
        end
    end

    // long hold-off on the receiver, counted here in cycles
    initial
    begin
        wait (hold_rx);
        repeat (600)
            @(negedge clk);
        hold_rx = 1'b0;
    end

    // ---------------- stimulus ----------------

    route_row_t directed_rows[$];

    initial
    begin
        route_row_t it;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, extremes, every mode
        directed_rows = '{
            '{rte_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_MISS, 7'd0},
            '{rte_pkg::MODE_PURGE, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_MISS, 7'd0},
            '{rte_pkg::MODE_LIST_VALID, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_MISS, 7'd0},
            '{rte_pkg::MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 32'hffff_ffff,
              32'hffff_ffff, 4'hf, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, rte_pkg::ST_OK, 7'd1},
            '{rte_pkg::MODE_ADD, 32'hffff_ffff, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_MISS, 7'd1},
            '{rte_pkg::MODE_ADD, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_OK, 7'd2},
            '{rte_pkg::MODE_ADD, rte_pkg::LOOPBACK_ADDR, 32'h0a00_0001, 8'd1, 32'd5, 32'd9,
              4'h3, 32'h0a00_00ff, 1'b1, 1'b0, 1'b1, rte_pkg::ST_OK, 7'd3},
            '{rte_pkg::MODE_ADD, 32'h0a00_0001, 32'hffff_ffff, 8'd1, 32'd7, 32'd50, 4'h3,
              32'h0a00_0001, 1'b1, 1'b0, 1'b1, rte_pkg::ST_OK, 7'd4},
            '{rte_pkg::MODE_ADD, 32'h0a00_0002, 32'h0a00_0001, 8'd2, 32'd1, 32'd0, 4'h5,
              32'h0, 1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_LOOKUP, 32'h0a00_0001, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b1, 1'b1, rte_pkg::ST_MISS, 7'd5},
            '{rte_pkg::MODE_LOOKUP, 32'h0a00_0001, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_UPDATE, 32'h0a00_0002, 32'h0a00_0001, 8'd2, 32'd2, 32'd3, 4'h5,
              32'h1, 1'b1, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_UPDATE, 32'h1234_5678, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b1, rte_pkg::ST_MISS, 7'd5},
            '{rte_pkg::MODE_LIST_VALID, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_LIST_NH, 32'h0, 32'h0a00_0001, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_PURGE, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_DEL_IFACE, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h9, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_DEL_IFACE, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_DELETE, 32'h1234_5678, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0, 32'h0,
              1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0},
            '{rte_pkg::MODE_DELETE, rte_pkg::LOOPBACK_ADDR, 32'h0, 8'h0, 32'h0, 32'h0, 4'h0,
              32'h0, 1'b0, 1'b0, 1'b0, rte_pkg::ST_OK, 7'd0}
        };
        for (int k = 0; k < rte_pkg::TABLE_DEPTH; k++)
            rt_used[k] = 1'b0;
        foreach (directed_rows[k])
        begin
            send_route_op(directed_rows[k]);
            // typed-in rows: predictor must agree with the table
            if (directed_rows[k].chk)
            begin
                if (pending_routes[$].status !== directed_rows[k].x_status
                    || pending_routes[$].count !== directed_rows[k].x_count)
                    fails_seen = 1'b1;
            end
        end
        drain_routes();

        // fill the table to hit the full case, with receiver held off meanwhile
        hold_rx = 1'b1;
        for (int k = 0; k <= rte_pkg::TABLE_DEPTH; k++)
        begin
            it = rand_route(0);
            it.mode = rte_pkg::MODE_ADD;
            it.dest = 32'h0b00_0000 + k;
            it.gw = 32'h0b00_0000 + k / 2;
            it.hops = 8'(k % 3);
            it.life = 32'(k * 3);
            send_route_op(it);
        end
        drain_routes();
        write_holddown(32'hffff_ffff);
        it = rand_route(0);
        it.mode = rte_pkg::MODE_PURGE;
        send_route_op(it);
        drain_routes();
        write_holddown(32'd100);
        it.mode = rte_pkg::MODE_PURGE;
        send_route_op(it);
        drain_routes();
        write_holddown(32'd0);
        send_route_op(it);
        drain_routes();

        // random part in phases with different holddowns and pacing
        for (int ph = 0; ph < 4; ph++)
        begin
            rx_quiet = (ph == 2);
            tx_quiet = (ph == 2);
            for (int k = 0; k < 8; k++)
                send_route_op(rand_route(ph == 1 ? 60 : 12));
            drain_routes();
            write_holddown(ph == 3 ? 32'hffff_ffff : 32'($urandom_range(150)));
        end

        if (mismatches == 0 && !fails_seen)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rte_pkg.sv
rtl/core/rte_ram.sv
rtl/core/rte_out_reg.sv
rtl/core/rte_engine.sv
rtl/core/route_table_engine_top.sv
test/tb_top.sv
